>>> rtl/tab_record_product_sum_parser_macros.svh
// assertion macros for the tab record product sum parser
`ifndef TAB_RECORD_PRODUCT_SUM_PARSER_MACROS_SVH
`define TAB_RECORD_PRODUCT_SUM_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TABPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle, reset not masked
`define TABPS_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/tabps_pkg.sv
// shared types and constants of the tab record product sum parser
`default_nettype none
package tabps_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 9;
  localparam int unsigned VAL_W          = 30;
  localparam int unsigned TOTAL_W        = 32;
  localparam int unsigned DCNT_W         = 4;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    PH_LINE     = 3'd0,
    PH_NAME     = 3'd1,
    PH_AMT_SIGN = 3'd2,
    PH_AMT_DIG  = 3'd3,
    PH_CST_SIGN = 3'd4,
    PH_CST_DIG  = 3'd5,
    PH_DISCARD  = 3'd6
  } phase_t;

  // work handed from the parser to the accumulator
  typedef struct packed {
    logic             add;     // add amount * cost to the total
    logic             report;  // emit a result
    logic             bad;     // result carries status incorrect and zero total
    logic             clear;   // total back to zero afterwards
    logic [VAL_W-1:0] amount;
    logic [VAL_W-1:0] cost;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/tab_record_product_sum_parser.sv
// top level of the tab record product sum parser
//
// takes a text stream one byte per transaction (in_tlast high marks end of
// stream and carries no byte). records are name TAB amount TAB cost NEWLINE;
// each number may carry one leading '+', at most MAX_DIGITS digits, and may be
// empty (counts as zero). amount times cost is added to a wrapping 32-bit
// total. at end of stream one result gives the total with status ok; the first
// malformed record gives status incorrect with zero total, after which bytes
// are dropped until end of stream, which then gives no result. end of stream
// always returns the block to its start state with the total cleared.
// rate: one byte per cycle while the queue has room. the parser decides a byte in the
// cycle it is taken; a four-entry command queue decouples it from the accumulator,
// which registers the 32-bit product in its multiply stage, then adds it to the
// total and registers each result in the output register. in_tready drops only
// while the queue is full, i.e. when the result side stalls.
`default_nettype none
module tab_record_product_sum_parser #(
  parameter int unsigned MAX_DIGITS = tabps_pkg::MAX_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] order_total
  output logic             out_tuser   // [0] status
);
  import tabps_pkg::*;

  `include "tab_record_product_sum_parser_macros.svh"

  logic   byte_accept;
  cmd_t   front_cmd;
  logic   front_cmd_valid;
  cmd_t   head_cmd;
  logic   q_full, q_empty;
  logic   q_push, q_pop;

  // a byte is taken whenever the queue has room, so a command is never lost
  assign in_tready   = !q_full;
  assign byte_accept = in_tvalid && in_tready;
  assign q_push      = byte_accept && front_cmd_valid;

  tabps_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_accept  (byte_accept),
    .text_byte    (in_tdata),
    .end_of_stream(in_tlast),
    .cmd          (front_cmd),
    .cmd_valid    (front_cmd_valid)
  );

  tabps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tabps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_status(out_tuser),
    .out_total (out_tdata)
  );

  // an incorrect-record result never carries a total
  `TABPS_ASSERT_SAME(a_bad_zero_total, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  // the accumulator only pulls from a queue that holds something
  `TABPS_ASSERT_SAME(a_pop_not_empty, clk, rst_n, q_pop, !q_empty)
  // reset leaves no result pending
  `TABPS_ASSERT_NEXT(a_reset_no_result, clk, !rst_n, !out_tvalid)

endmodule
`default_nettype wire

>>> rtl/tabps_front.sv
// byte parser: tracks the record phase, builds numbers and issues commands
`default_nettype none
module tabps_front #(
  parameter int unsigned MAX_DIGITS = tabps_pkg::MAX_DIGITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_accept,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_stream,
  output tabps_pkg::cmd_t    cmd,
  output logic               cmd_valid
);
  import tabps_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [VAL_W-1:0]    amount_r, amount_nxt;
  logic [VAL_W-1:0]    cost_r, cost_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;

  logic                is_digit;
  logic                can_take;
  logic [VAL_W-1:0]    digit_val;
  logic [VAL_W-1:0]    amount_acc;
  logic [VAL_W-1:0]    cost_acc;

  assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign can_take  = is_digit && (dcnt_r < DCNT_W'(MAX_DIGITS));
  assign digit_val = VAL_W'(text_byte - CH_ZERO);
  // v * 10 + d as two shifts and two adds, wrapped to the value width
  assign amount_acc = (amount_r << 3) + (amount_r << 1) + digit_val;
  assign cost_acc   = (cost_r << 3) + (cost_r << 1) + digit_val;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (end_of_stream) begin
      phase_nxt = PH_LINE;
    end else begin
      unique case (phase_r)
        PH_DISCARD: phase_nxt = PH_DISCARD;
        PH_AMT_SIGN, PH_AMT_DIG: begin
          if (phase_r == PH_AMT_SIGN && text_byte == CH_PLUS) phase_nxt = PH_AMT_DIG;
          else if (can_take)                                 phase_nxt = PH_AMT_DIG;
          else if (text_byte == CH_TAB)                      phase_nxt = PH_CST_SIGN;
          else                                               phase_nxt = PH_DISCARD;
        end
        PH_CST_SIGN, PH_CST_DIG: begin
          if (phase_r == PH_CST_SIGN && text_byte == CH_PLUS) phase_nxt = PH_CST_DIG;
          else if (can_take)                                 phase_nxt = PH_CST_DIG;
          else if (text_byte == CH_NEWLINE)                  phase_nxt = PH_LINE;
          else                                               phase_nxt = PH_DISCARD;
        end
        default: begin
          if (text_byte == CH_TAB)          phase_nxt = PH_AMT_SIGN;
          else if (text_byte == CH_NEWLINE) phase_nxt = PH_DISCARD;
          else                              phase_nxt = PH_NAME;
        end
      endcase
    end
  end

  // datapath and command outputs
  always_comb begin
    amount_nxt = amount_r;
    cost_nxt   = cost_r;
    dcnt_nxt   = dcnt_r;
    cmd_valid  = 1'b0;
    cmd        = '{add: 1'b0, report: 1'b0, bad: 1'b0, clear: 1'b0,
                   amount: amount_r, cost: cost_r};
    if (end_of_stream) begin
      amount_nxt = '0;
      cost_nxt   = '0;
      dcnt_nxt   = '0;
      cmd_valid  = 1'b1;
      cmd.clear  = 1'b1;
      unique case (phase_r)
        PH_DISCARD: ;
        PH_CST_SIGN, PH_CST_DIG: begin
          cmd.add    = 1'b1;
          cmd.report = 1'b1;
        end
        PH_NAME, PH_AMT_SIGN, PH_AMT_DIG: begin
          cmd.report = 1'b1;
          cmd.bad    = 1'b1;
        end
        default: cmd.report = 1'b1;
      endcase
    end else begin
      unique case (phase_r)
        PH_DISCARD: ;
        PH_AMT_SIGN, PH_AMT_DIG: begin
          if (phase_r == PH_AMT_SIGN && text_byte == CH_PLUS) begin
          end else if (can_take) begin
            amount_nxt = amount_acc;
            dcnt_nxt   = dcnt_r + 1'b1;
          end else if (text_byte == CH_TAB) begin
            cost_nxt = '0;
            dcnt_nxt = '0;
          end else begin
            cmd_valid  = 1'b1;
            cmd.report = 1'b1;
            cmd.bad    = 1'b1;
          end
        end
        PH_CST_SIGN, PH_CST_DIG: begin
          if (phase_r == PH_CST_SIGN && text_byte == CH_PLUS) begin
          end else if (can_take) begin
            cost_nxt = cost_acc;
            dcnt_nxt = dcnt_r + 1'b1;
          end else if (text_byte == CH_NEWLINE) begin
            cmd_valid = 1'b1;
            cmd.add   = 1'b1;
          end else begin
            cmd_valid  = 1'b1;
            cmd.report = 1'b1;
            cmd.bad    = 1'b1;
          end
        end
        default: begin
          if (text_byte == CH_TAB) begin
            amount_nxt = '0;
            dcnt_nxt   = '0;
          end else if (text_byte == CH_NEWLINE) begin
            cmd_valid  = 1'b1;
            cmd.report = 1'b1;
            cmd.bad    = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LINE;
      amount_r <= '0;
      cost_r   <= '0;
      dcnt_r   <= '0;
    end else if (byte_accept) begin
      phase_r  <= phase_nxt;
      amount_r <= amount_nxt;
      cost_r   <= cost_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tabps_queue.sv
// short command queue between parser and accumulator
`default_nettype none
module tabps_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tabps_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output tabps_pkg::cmd_t    head_cmd,
  output logic               full,
  output logic               empty
);
  import tabps_pkg::*;

  cmd_t                slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/tabps_back.sv
// accumulator: multiply stage, total update and output register
`default_nettype none
module tabps_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_valid,
  input  wire tabps_pkg::cmd_t              cmd,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_status,
  output logic [tabps_pkg::TOTAL_W-1:0]     out_total
);
  import tabps_pkg::*;

  // multiply stage
  logic                 m_valid_r;
  logic                 m_add_r, m_report_r, m_bad_r, m_clear_r;
  logic [TOTAL_W-1:0]   m_prod_r;
  logic                 m_adv;

  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   sum;

  logic                 out_valid_r;
  logic                 out_status_r;
  logic [TOTAL_W-1:0]   out_total_r;

  assign m_adv   = m_valid_r && (!m_report_r || !out_valid_r || out_ready);
  assign cmd_pop = cmd_valid && (!m_valid_r || m_adv);
  assign sum     = m_add_r ? total_r + m_prod_r : total_r;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      m_add_r    <= cmd.add;
      m_report_r <= cmd.report;
      m_bad_r    <= cmd.bad;
      m_clear_r  <= cmd.clear;
      // only the low word of the product reaches the wrapping total
      m_prod_r   <= TOTAL_W'(TOTAL_W'(cmd.amount) * TOTAL_W'(cmd.cost));
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv && m_report_r) begin
      out_status_r <= m_bad_r;
      out_total_r  <= m_bad_r ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop)    m_valid_r <= 1'b1;
      else if (m_adv) m_valid_r <= 1'b0;
      if (m_adv) total_r <= m_clear_r ? '0 : sum;
      if (m_adv && m_report_r) out_valid_r <= 1'b1;
      else if (out_ready)      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_total  = out_total_r;

endmodule
`default_nettype wire

>>> tb/sv/tab_record_checker.sv
// checker for the tab record parser: predicts every report and compares it with the block's output
`timescale 1ns / 1ps

module tab_record_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_stream
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [31:0] order_total
  input  wire logic        out_tuser,  // [0] status
  output int               mismatch_count,
  output int               open_results
);
  import tabps_pkg::*;

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] total;
  } order_report_t;

  order_report_t expected_reports[$];
  order_report_t predicted_report;
  order_report_t oldest_report;

  // own copy of the parser state
  phase_t              parse_phase;
  logic [VAL_W-1:0]    amount_acc;
  logic [VAL_W-1:0]    cost_acc;
  logic [DCNT_W-1:0]   digits_seen;
  logic [TOTAL_W-1:0]  order_sum;

  function automatic void clear_parse();
    parse_phase = PH_LINE;
    amount_acc  = '0;
    cost_acc    = '0;
    digits_seen = '0;
    order_sum   = '0;
  endfunction

  function automatic void add_product();
    logic [63:0] product;
    product   = 64'(amount_acc) * 64'(cost_acc);
    order_sum = order_sum + product[TOTAL_W-1:0];
  endfunction

  // decimal accumulate, refused for a non-digit or once the digit budget is spent
  function automatic bit accept_digit(input logic [7:0] c, input bit into_cost);
    logic [VAL_W-1:0] d;
    if (c < CH_ZERO || c > CH_NINE || digits_seen >= MAX_DIGITS_DEF)
      return 1'b0;
    d = VAL_W'(c - CH_ZERO);
    if (into_cost)
      cost_acc = cost_acc * VAL_W'(10) + d;
    else
      amount_acc = amount_acc * VAL_W'(10) + d;
    digits_seen = digits_seen + 1'b1;
    return 1'b1;
  endfunction

  // one transaction into the parser; returns 1 when it causes a report
  function automatic bit predict_byte(input logic [7:0] c, input logic eos,
                                      output order_report_t rep);
    if (eos) begin
      if (parse_phase == PH_DISCARD) begin
        clear_parse();
        return 1'b0;
      end
      if (parse_phase == PH_CST_SIGN || parse_phase == PH_CST_DIG) begin
        add_product();
        parse_phase = PH_LINE;
      end
      if (parse_phase == PH_LINE)
        rep = '{status: 1'b0, total: order_sum};
      else
        rep = '{status: 1'b1, total: '0};
      clear_parse();
      return 1'b1;
    end
    case (parse_phase)
      PH_DISCARD: return 1'b0;
      PH_AMT_SIGN, PH_AMT_DIG: begin
        if (parse_phase == PH_AMT_SIGN && c == CH_PLUS) begin
          parse_phase = PH_AMT_DIG;
          return 1'b0;
        end
        if (accept_digit(c, 1'b0)) begin
          parse_phase = PH_AMT_DIG;
          return 1'b0;
        end
        if (c == CH_TAB) begin
          cost_acc    = '0;
          digits_seen = '0;
          parse_phase = PH_CST_SIGN;
          return 1'b0;
        end
      end
      PH_CST_SIGN, PH_CST_DIG: begin
        if (parse_phase == PH_CST_SIGN && c == CH_PLUS) begin
          parse_phase = PH_CST_DIG;
          return 1'b0;
        end
        if (accept_digit(c, 1'b1)) begin
          parse_phase = PH_CST_DIG;
          return 1'b0;
        end
        if (c == CH_NEWLINE) begin
          add_product();
          parse_phase = PH_LINE;
          return 1'b0;
        end
      end
      default: begin
        if (c == CH_TAB) begin
          amount_acc  = '0;
          digits_seen = '0;
          parse_phase = PH_AMT_SIGN;
          return 1'b0;
        end
        if (c != CH_NEWLINE) begin
          parse_phase = PH_NAME;
          return 1'b0;
        end
      end
    endcase
    // malformed record
    rep         = '{status: 1'b1, total: '0};
    parse_phase = PH_DISCARD;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_reports.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d total %0d",
                   $time, out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          oldest_report = expected_reports.pop_front();
          if (out_tuser !== oldest_report.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, oldest_report.status, out_tuser);
            mismatch_count++;
          end
          if (out_tdata !== oldest_report.total) begin
            $display("%0t: order_total mismatch, expected %0d actual %0d",
                     $time, oldest_report.total, out_tdata);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (predict_byte(in_tdata, in_tlast, predicted_report))
          expected_reports.push_back(predicted_report);
      end
    end
    open_results = expected_reports.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// top of the tab record parser testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import tabps_pkg::*;

  localparam int RANDOM_ITEMS = 1950;    // bytes sent in all before the random part ends
  localparam int IDLE_PCT     = 23;      // chance of an idle cycle on either side
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;      // settling margin after the last report is out
  localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest correct run

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [31:0] out_tdata;
  wire logic        out_tuser;

  int mismatch_count;
  int open_results;
  int items_sent    = 0;
  int hold_requests = 0;   // bumped to ask the result sink for a long hold-off
  int cycle_count   = 0;
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;

  logic [7:0] stream_bytes[$];  // bytes of the stream being built

  tab_record_product_sum_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] text_byte
    .in_tlast   (in_tlast),    // end_of_stream
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] order_total
    .out_tuser  (out_tuser)    // [0] status
  );

  tab_record_checker report_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog, independent of every handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result sink: random back-pressure, plus a long hold-off counted here on request
  initial begin : result_sink
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_on) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one transaction on the input side; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // end of stream carries a random byte that the block must ignore
  task automatic send_eos();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], 1'b0);
  endtask

  // stop offering and wait until every predicted report has come out
  task automatic settle_results();
    in_tvalid <= 1'b0;
    wait (open_results == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // any byte except the two separators, so it stays inside the name
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_TAB || c == CH_NEWLINE);
    return c;
  endfunction

  function automatic void put_name();
    int n;
    n = $urandom_range(5);
    repeat (n) stream_bytes.push_back(name_char());
  endfunction

  // optional plus then ndig digits, now and then all nines for the largest values
  function automatic void put_digits(input int ndig, input bit plus);
    bit all_nines;
    all_nines = ($urandom_range(3) == 0);
    if (plus)
      stream_bytes.push_back(CH_PLUS);
    for (int i = 0; i < ndig; i++)
      stream_bytes.push_back(all_nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(9)));
  endfunction

  // empty numbers and full-width numbers favoured
  function automatic int pick_digits();
    int r;
    r = $urandom_range(9);
    if (r < 2)
      return 0;
    if (r < 4)
      return MAX_DIGITS_DEF;
    return $urandom_range(MAX_DIGITS_DEF - 1, 1);
  endfunction

  function automatic void put_record();
    put_name();
    stream_bytes.push_back(CH_TAB);
    put_digits(pick_digits(), $urandom_range(3) == 0);
    stream_bytes.push_back(CH_TAB);
    put_digits(pick_digits(), $urandom_range(3) == 0);
  endfunction

  // mostly well-formed records with random content; the rest broken or noisy
  function automatic void build_stream();
    int  nrec;
    int  kind;
    bit  open_end;
    stream_bytes.delete();
    kind     = $urandom_range(99);
    nrec     = $urandom_range(4);
    open_end = (kind < 70) && ($urandom_range(3) == 0);
    for (int r = 0; r < nrec; r++) begin
      put_record();
      if (!(open_end && r == nrec - 1))
        stream_bytes.push_back(CH_NEWLINE);
    end
    if (kind < 70) begin
      // well formed, possibly ending inside the cost field
    end else if (kind < 78) begin
      // one byte overwritten with noise
      if (stream_bytes.size() > 0)
        stream_bytes[$urandom_range(stream_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 84) begin
      // one digit more than allowed
      put_name();
      stream_bytes.push_back(CH_TAB);
      put_digits(MAX_DIGITS_DEF + 1, 1'($urandom_range(1)));
    end else if (kind < 88) begin
      // a plus after the optional sign and up to two digits: stray unless both are absent
      put_name();
      stream_bytes.push_back(CH_TAB);
      put_digits($urandom_range(2), 1'($urandom_range(1)));
      stream_bytes.push_back(CH_PLUS);
    end else if (kind < 92) begin
      stream_bytes.push_back(CH_NEWLINE);  // empty line
    end else if (kind < 96) begin
      // newline before the cost field
      put_name();
      stream_bytes.push_back(CH_TAB);
      put_digits(pick_digits(), 1'($urandom_range(1)));
      stream_bytes.push_back(CH_NEWLINE);
    end else begin
      // stream cut off inside the name or the amount
      stream_bytes.push_back(name_char());
      if ($urandom_range(1)) begin
        stream_bytes.push_back(CH_TAB);
        put_digits(pick_digits(), 1'($urandom_range(1)));
      end
    end
    // a few trailing bytes, dropped when a fault has already been seen
    if (kind >= 70 && $urandom_range(1))
      repeat ($urandom_range(6)) stream_bytes.push_back(8'($urandom_range(255)));
  endfunction

  task automatic send_stream();
    foreach (stream_bytes[i])
      send_byte(stream_bytes[i], 1'b0);
    send_eos();
  endtask

  // receiver holds off while short streams keep coming, so the command queue fills
  task automatic flood_during_hold();
    tx_idle_on = 1'b0;
    hold_requests++;
    repeat (12) begin
      send_text("n\t12\t+34\n");
      send_eos();
    end
    tx_idle_on = 1'b1;
  endtask

  initial begin : stimulus
    int stream_idx;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_eos();                                   // end at line start, total zero
    send_text("\n"); send_eos();                  // empty line, then end while discarding
    send_byte(8'hFF, 1'b0); send_text("\t++");    // second plus is a stray character
    send_eos();
    send_byte(8'h00, 1'b0); send_text("\n");      // newline inside the name
    send_eos();
    send_text("\t\t\n\t3\t+4"); send_eos();       // empty numbers, end inside the cost
    send_text("\t1"); send_eos();                 // end inside the amount
    send_text("q"); send_eos();                   // end inside the name
    send_text("\t1234567890"); send_eos();        // tenth digit
    settle_results();

    // random part
    stream_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // a run of streams with no idling on either side
      tx_idle_on = !(stream_idx >= 8 && stream_idx < 16);
      rx_idle_on = tx_idle_on;
      if (stream_idx == 20)
        flood_during_hold();
      if (stream_idx == 30)
        settle_results();                         // sender pauses until all reports are in
      build_stream();
      send_stream();
      stream_idx++;
    end

    settle_results();
    if (mismatch_count == 0 && open_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> tab_record_product_sum_parser.f
+incdir+rtl
rtl/tabps_pkg.sv
rtl/tabps_front.sv
rtl/tabps_queue.sv
rtl/tabps_back.sv
rtl/tab_record_product_sum_parser.sv
tb/sv/tab_record_checker.sv
tb/sv/tb_top.sv
